// ===== sv/mpqt_pkg.sv =====
package mpqt_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    // broadcast from control to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t item;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    // higher priority first, larger value breaks a tie
    function automatic logic ranks_above(entry_t a, entry_t b);
        logic result;
        if (a.prio != b.prio) begin
            result = (a.prio > b.prio);
        end else begin
            result = (a.value > b.value);
        end
        return result;
    endfunction

endpackage

// ===== sv/mpqt_cell.sv =====
module mpqt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 8
) (
    input  logic               aclk,
    input  mpqt_pkg::cmd_t     cmd_i,
    input  logic [CNT_W-1:0]   count_i,
    input  mpqt_pkg::entry_t   prev_entry_i,
    input  logic               prev_lower_i,
    input  mpqt_pkg::entry_t   next_entry_i,
    output mpqt_pkg::entry_t   entry_o,
    output logic               lower_o
);

    mpqt_pkg::entry_t entry_reg;
    mpqt_pkg::entry_t entry_next;
    logic             occupied;

    assign occupied = (count_i > CNT_W'(INDEX));
    // the new item belongs at or above this cell
    assign lower_o  = !occupied || mpqt_pkg::ranks_above(cmd_i.item, entry_reg);
    assign entry_o  = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd_i.pop) begin
            entry_next = next_entry_i;
        end else if (cmd_i.push && lower_o) begin
            if (prev_lower_i) begin
                entry_next = prev_entry_i;
            end else begin
                entry_next = cmd_i.item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/max_priority_queue_table_unit.sv =====
// channel | ports                                         | direction
// s_      | s_kind, s_item_value, s_item_priority         | request in
// m_      | m_status, m_removed_*, m_top_*, m_entry_count | result out
//
// for each item, every cell of the sorted chain updates when it is accepted,
// then the busy state loads the result register once the old one is taken.
// one request is in flight at a time; a new request is taken while the
// previous result still waits in the output register.
// reset is synchronous, active low, and empties the queue at once.
// m_ready low holds the result and stalls the next request in the busy stage.
module max_priority_queue_table_unit #(
    parameter int DEPTH = mpqt_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_item_value,
    input  logic signed [15:0] s_item_priority,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_removed_value,
    output logic signed [15:0] m_removed_priority,
    output logic               m_top_valid,
    output logic signed [31:0] m_top_value,
    output logic signed [15:0] m_top_priority,
    output logic [7:0]         m_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    mpqt_pkg::state_t state_reg;
    mpqt_pkg::state_t state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             load;
    mpqt_pkg::cmd_t   cmd;

    mpqt_pkg::entry_t chain [DEPTH];
    logic             lower [DEPTH];

    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    mpqt_pkg::entry_t removed_reg;
    mpqt_pkg::entry_t removed_next;

    logic             m_valid_reg;
    logic             m_valid_next;
    logic [1:0]       m_status_reg;
    mpqt_pkg::entry_t m_removed_reg;
    logic             m_top_valid_reg;
    mpqt_pkg::entry_t m_top_reg;
    logic [7:0]       m_count_reg;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign accept = s_valid && s_ready;

    assign cmd.push       = accept && (s_kind == mpqt_pkg::KIND_PUSH) && !full;
    assign cmd.pop        = accept && (s_kind == mpqt_pkg::KIND_POP) && !empty;
    assign cmd.item.value = s_item_value;
    assign cmd.item.prio  = s_item_priority;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            mpqt_pkg::entry_t prev_entry;
            mpqt_pkg::entry_t next_entry;
            logic             prev_lower;
            if (i == 0) begin : g_first
                assign prev_entry = '0;
                assign prev_lower = 1'b0;
            end else begin : g_mid
                assign prev_entry = chain[i-1];
                assign prev_lower = lower[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign next_entry = '0;
            end else begin : g_body
                assign next_entry = chain[i+1];
            end
            mpqt_cell #(
                .INDEX (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk         (aclk),
                .cmd_i        (cmd),
                .count_i      (count_reg),
                .prev_entry_i (prev_entry),
                .prev_lower_i (prev_lower),
                .next_entry_i (next_entry),
                .entry_o      (chain[i]),
                .lower_o      (lower[i])
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpqt_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = mpqt_pkg::ST_BUSY;
                end
            end
            mpqt_pkg::ST_BUSY: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = mpqt_pkg::ST_IDLE;
                end
            end
            default: state_next = mpqt_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_ready = 1'b0;
        load    = 1'b0;
        case (state_reg)
            mpqt_pkg::ST_IDLE: s_ready = aresetn;
            mpqt_pkg::ST_BUSY: load    = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
                load    = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        status_next  = status_reg;
        removed_next = removed_reg;
        if (accept) begin
            status_next  = mpqt_pkg::STATUS_OK;
            removed_next = '0;
            if (s_kind == mpqt_pkg::KIND_PUSH) begin
                if (full) begin
                    status_next = mpqt_pkg::STATUS_FULL;
                end
            end else if (empty) begin
                status_next = mpqt_pkg::STATUS_EMPTY;
            end else begin
                removed_next = chain[0];
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mpqt_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        if (load) begin
            m_status_reg    <= status_reg;
            m_removed_reg   <= removed_reg;
            m_top_valid_reg <= !empty;
            m_top_reg       <= empty ? '0 : chain[0];
            m_count_reg     <= 8'(count_reg);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_removed_value    = m_removed_reg.value;
    assign m_removed_priority = m_removed_reg.prio;
    assign m_top_valid        = m_top_valid_reg;
    assign m_top_value        = m_top_reg.value;
    assign m_top_priority     = m_top_reg.prio;
    assign m_entry_count      = m_count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_push_count : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the count");

    a_full_drop : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_kind == mpqt_pkg::KIND_PUSH) && full |=> $stable(count_reg))
        else $error("push into a full queue changed the count");

    a_result_from_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == mpqt_pkg::ST_BUSY))
        else $error("result appeared without a request in flight");

    a_sorted_head : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > CNT_W'(1)) |-> !mpqt_pkg::ranks_above(chain[1], chain[0]))
        else $error("head cell does not hold the top entry");
`endif

endmodule
